// ===== src/bps_pkg.sv =====
// Shared types, codes and pattern tables of the buzzer pattern sequencer.
// Used by bps_engine and buzzer_pattern_sequencer; depends on nothing else.
package bps_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PLAY = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    localparam logic [3:0] TONE_NONE      = 4'd0;
    localparam logic [3:0] TONE_CLICK     = 4'd1;
    localparam logic [3:0] TONE_EMERGENCY = 4'd7;
    localparam logic [3:0] TONE_SOS       = 4'd8;
    localparam logic [3:0] TONE_TEST      = 4'd12;

    localparam logic [2:0] CAT_NONE = 3'd7;

    localparam logic [1:0] REG_MASTER_ENABLE = 2'd0;
    localparam logic [1:0] REG_NIGHT_MUTE    = 2'd1;
    localparam logic [1:0] REG_CATEGORY_MASK = 2'd2;

    localparam int unsigned STEP_COUNT = 55;

    localparam logic [7:0] STEP_DUR [0:STEP_COUNT-1] = '{
        8'd40,
        8'd35, 8'd50, 8'd35,
        8'd40, 8'd50, 8'd40, 8'd50, 8'd60,
        8'd50, 8'd70, 8'd50,
        8'd35, 8'd110, 8'd55,
        8'd90, 8'd70, 8'd90, 8'd70, 8'd120,
        8'd70, 8'd60, 8'd70, 8'd60, 8'd70, 8'd180, 8'd210, 8'd60, 8'd210,
        8'd60, 8'd210, 8'd180, 8'd70, 8'd60, 8'd70, 8'd60, 8'd70,
        8'd12, 8'd35, 8'd14, 8'd35, 8'd12, 8'd35, 8'd14,
        8'd18, 8'd35, 8'd32,
        8'd14, 8'd30, 8'd65,
        8'd60, 8'd60, 8'd60, 8'd60, 8'd100
    };

    typedef struct packed {
        logic       master_enable;
        logic       night_mute;
        logic [6:0] category_mask;
    } cfg_t;

    typedef struct packed {
        logic [3:0] active_tone;
        logic [4:0] step_index;
        logic [7:0] step_elapsed_ms;
        logic       pattern_level;
        logic [3:0] click_remaining;
    } seq_state_t;

    typedef struct packed {
        logic       buzzer_level;
        logic       playing;
        logic [3:0] current_tone;
    } seq_status_t;

    function automatic logic [7:0] step_dur(input logic [5:0] idx);
        if (idx < 6'(STEP_COUNT)) begin
            return STEP_DUR[idx];
        end
        return 8'd255;
    endfunction

    function automatic logic [5:0] tone_off(input logic [3:0] tone);
        logic [5:0] off;
        unique case (tone)
            4'd3:    off = 6'd1;
            4'd4:    off = 6'd4;
            4'd5:    off = 6'd9;
            4'd6:    off = 6'd12;
            4'd7:    off = 6'd15;
            4'd8:    off = 6'd20;
            4'd9:    off = 6'd37;
            4'd10:   off = 6'd44;
            4'd11:   off = 6'd47;
            4'd12:   off = 6'd50;
            default: off = 6'd0;
        endcase
        return off;
    endfunction

    function automatic logic [4:0] tone_len(input logic [3:0] tone);
        logic [4:0] len;
        unique case (tone)
            4'd2:    len = 5'd1;
            4'd3:    len = 5'd3;
            4'd4:    len = 5'd5;
            4'd5:    len = 5'd3;
            4'd6:    len = 5'd3;
            4'd7:    len = 5'd5;
            4'd8:    len = 5'd17;
            4'd9:    len = 5'd7;
            4'd10:   len = 5'd3;
            4'd11:   len = 5'd3;
            4'd12:   len = 5'd5;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] tone_cat(input logic [3:0] tone);
        logic [2:0] cat;
        unique case (tone)
            4'd1:                 cat = 3'd0;
            4'd2:                 cat = 3'd1;
            4'd3:                 cat = 3'd2;
            4'd4:                 cat = 3'd3;
            4'd5, 4'd6:           cat = 3'd4;
            4'd7, 4'd8:           cat = 3'd5;
            4'd9, 4'd10, 4'd11:   cat = 3'd6;
            default:              cat = CAT_NONE;
        endcase
        return cat;
    endfunction

endpackage

// ===== src/bps_engine.sv =====
// Sequencer state and its next-state logic for one transfer.
// Depends on bps_pkg for the tables, codes and the state and status structs.
module bps_engine #(
    parameter int unsigned CLICK_TICKS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_accept,
    input  logic [1:0]           item_cmd,
    input  logic [3:0]           item_tone,
    input  logic                 item_force_req,
    input  logic                 item_is_night,
    input  bps_pkg::cfg_t        cfg,
    output bps_pkg::seq_status_t status_next
);
    import bps_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (item_accept) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic [4:0] len;
        logic [7:0] elapsed_inc;
        logic [4:0] step_inc;
        logic [7:0] dur;
        logic       bypass;
        logic       night_block;
        logic       cat_ok;
        logic [7:0] cat_mask_ext;
        logic       pass;

        state_next   = state_reg;
        len          = tone_len(state_reg.active_tone);
        elapsed_inc  = (state_reg.step_elapsed_ms == 8'd255) ? 8'd255
                                                             : state_reg.step_elapsed_ms + 8'd1;
        step_inc     = state_reg.step_index + 5'd1;
        dur          = step_dur(tone_off(state_reg.active_tone)
                                + {1'b0, state_reg.step_index});
        bypass       = item_force_req || (item_tone == TONE_TEST);
        night_block  = cfg.night_mute && item_is_night
                       && (item_tone != TONE_EMERGENCY) && (item_tone != TONE_SOS);
        cat_mask_ext = {1'b1, cfg.category_mask};
        cat_ok       = cat_mask_ext[tone_cat(item_tone)];
        pass         = bypass || (cfg.master_enable && !night_block && cat_ok
                                  && !(state_reg.active_tone > item_tone));

        unique case (item_cmd)
            CMD_TICK: begin
                if (state_reg.click_remaining != 4'd0) begin
                    state_next.click_remaining = state_reg.click_remaining - 4'd1;
                end
                if (state_reg.active_tone != TONE_NONE) begin
                    if (len == 5'd0 || state_reg.step_index >= len) begin
                        state_next.active_tone     = TONE_NONE;
                        state_next.step_index      = '0;
                        state_next.step_elapsed_ms = '0;
                        state_next.pattern_level   = 1'b0;
                    end else begin
                        state_next.step_elapsed_ms = elapsed_inc;
                        if (elapsed_inc >= dur) begin
                            if (step_inc >= len) begin
                                state_next.active_tone     = TONE_NONE;
                                state_next.step_index      = '0;
                                state_next.step_elapsed_ms = '0;
                                state_next.pattern_level   = 1'b0;
                            end else begin
                                state_next.step_index      = step_inc;
                                state_next.step_elapsed_ms = '0;
                                state_next.pattern_level   = ~step_inc[0];
                            end
                        end
                    end
                end
            end
            CMD_PLAY: begin
                priority if (item_tone == TONE_NONE) begin
                    state_next.active_tone     = TONE_NONE;
                    state_next.step_index      = '0;
                    state_next.step_elapsed_ms = '0;
                    state_next.pattern_level   = 1'b0;
                end else if (item_tone <= TONE_TEST && pass) begin
                    if (item_tone == TONE_CLICK) begin
                        state_next.click_remaining = 4'(CLICK_TICKS);
                    end else begin
                        state_next.active_tone     = item_tone;
                        state_next.step_index      = '0;
                        state_next.step_elapsed_ms = '0;
                        state_next.pattern_level   = 1'b1;
                    end
                end else begin
                end
            end
            CMD_STOP: begin
                state_next.active_tone     = TONE_NONE;
                state_next.step_index      = '0;
                state_next.step_elapsed_ms = '0;
                state_next.pattern_level   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign status_next.buzzer_level = state_next.pattern_level
                                      || (state_next.click_remaining != 4'd0);
    assign status_next.playing      = (state_next.active_tone != TONE_NONE);
    assign status_next.current_tone = state_next.active_tone;

endmodule

// ===== src/buzzer_pattern_sequencer.sv =====
// Top level of the buzzer pattern sequencer: APB registers, handshake and result register.
// Depends on bps_pkg and bps_engine.
// A result is registered and is valid in the cycle after its input transfer.
// Throughput: one transfer per cycle while results are taken; the result register is refilled as it is taken.
// Reset (aresetn low at a clock edge) clears the tone state and loads the registers.
module buzzer_pattern_sequencer #(
    parameter int unsigned CLICK_TICKS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [3:0]  s_tone,
    input  logic        s_force_req,
    input  logic        s_is_night,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_buzzer_level,
    output logic        m_playing,
    output logic [3:0]  m_current_tone
);
    import bps_pkg::*;

    cfg_t        cfg_reg;
    seq_status_t status_next;
    seq_status_t result_reg;
    logic        m_valid_reg;
    logic        in_accept;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_enable <= 1'b1;
            cfg_reg.night_mute    <= 1'b0;
            cfg_reg.category_mask <= 7'h7f;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MASTER_ENABLE: cfg_reg.master_enable <= pwdata[0];
                REG_NIGHT_MUTE:    cfg_reg.night_mute    <= pwdata[0];
                REG_CATEGORY_MASK: cfg_reg.category_mask <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MASTER_ENABLE: prdata = {31'd0, cfg_reg.master_enable};
            REG_NIGHT_MUTE:    prdata = {31'd0, cfg_reg.night_mute};
            REG_CATEGORY_MASK: prdata = {25'd0, cfg_reg.category_mask};
            default:           prdata = 32'd0;
        endcase
    end

    bps_engine #(
        .CLICK_TICKS(CLICK_TICKS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_accept   (in_accept),
        .item_cmd      (s_cmd),
        .item_tone     (s_tone),
        .item_force_req(s_force_req),
        .item_is_night (s_is_night),
        .cfg           (cfg_reg),
        .status_next   (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_buzzer_level = result_reg.buzzer_level;
    assign m_playing      = result_reg.playing;
    assign m_current_tone = result_reg.current_tone;

    // A stop transfer always leaves the sequencer without an active tone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_cmd == CMD_STOP) |=> (!m_playing && m_current_tone == TONE_NONE))
        else $error("tone still active after stop");

    // A forced click always drives the buzzer on the next result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_cmd == CMD_PLAY && s_tone == TONE_CLICK && s_force_req)
        |=> m_buzzer_level)
        else $error("forced click did not drive the buzzer");

    // Every accepted transfer produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_valid)
        else $error("result missing after input transfer");

    // The playing flag and the tone code agree.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_playing == (m_current_tone != TONE_NONE)))
        else $error("playing flag disagrees with tone code");

endmodule
